// ----- hw/rtl/sbm_pkg.sv -----
// Shared types and constants for the SAD block-matching stereo block.
`timescale 1ns / 1ps
`default_nettype none
package sbm_pkg;
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int MaxDisp   = 64;
  localparam int MaxHalf   = 7;
  localparam int LineRows  = 2 * MaxHalf + 2;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int DispW     = $clog2(MaxDisp);
  localparam int SlotW     = $clog2(LineRows);
  localparam int AddrW     = SlotW + ColW;
  localparam int SumW      = 28;
  localparam logic [SumW-1:0] FarCost = SumW'(1000000);

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DISP   = 2'd2;
  localparam logic [1:0] REG_HALF   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_READ, ST_ACC, ST_NEXT, ST_SEND
  } sbm_state_t;

  typedef struct packed {
    logic [7:0] left_pixel;
    logic [7:0] right_pixel;
    logic       is_flush;
  } sbm_in_t;

  typedef struct packed {
    logic [DispW-1:0] disparity;
    logic [RowW-1:0]  out_row;
    logic [ColW-1:0]  out_col;
    logic             frame_end;
  } sbm_out_t;
endpackage
`default_nettype wire

// ----- hw/rtl/sbm_stream_if.sv -----
// Valid/ready channel interface.
`timescale 1ns / 1ps
`default_nettype none
interface sbm_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sad_block_match_stereo_wta.sv -----
// Top level of the SAD block-matching stereo disparity block.
`timescale 1ns / 1ps
`default_nettype none
// Streams rectified left/right pixel pairs in raster order and returns, per
// pixel, the disparity of least SAD over a (2h+1)-square window (ties to the
// smaller d, border pixels give 0). Pixels sit in two line memories of 16 rows
// by 1024 columns. Each item is handled one at a time: the pixel is written,
// then if a result is due its window is summed one left/right pair at a time,
// each pair read from the line memories and then accumulated, with a compare
// after each disparity level. Border results skip the summing, and items with
// no result return to idle. Any configuration write restarts the frame.
// Line memories need no clearing: only pixels of the current frame are read.
module sad_block_match_stereo_wta
  import sbm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sbm_stream_if.sink   in_ch,
  sbm_stream_if.source out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  logic [10:0] width_r, height_r;
  logic [6:0]  levels_r;
  logic [2:0]  half_r;
  logic [20:0] taken_r, given_r;   // one bit above 2^20 so a full 1024x1024 frame fits
  logic [ColW-1:0] wcol_r, rcol_r;   // raster position of next pixel / result
  logic [RowW:0]   wrow_r, rrow_r;
  sbm_state_t state_r, state_nxt;
  sbm_out_t   res_r;
  logic [7:0] lmem [LineRows*MaxWidth];
  logic [7:0] rmem [LineRows*MaxWidth];
  logic [7:0] lq_r, rq_r;
  logic       far_r;
  logic [6:0] d_r;
  logic [4:0] wr_r, wc_r;   // window offsets 0..2h
  logic [SumW-1:0] sum_r, best_r;

  wire [20:0] total = 21'(width_r) * 21'(height_r);
  wire [4:0]  span  = {1'b0, half_r, 1'b0};
  wire [RowW:0] lastr0 = rrow_r + (RowW+1)'(half_r);
  wire [RowW:0] lastr = (lastr0 > (RowW+1)'(height_r - 11'd1)) ?
                        (RowW+1)'(height_r - 11'd1) : lastr0;
  wire [20:0] need = 21'(lastr + 1'b1) * 21'(width_r);
  wire due = (given_r < total) && (taken_r >= need);
  wire border = (11'(rcol_r) < 11'(half_r)) || (rrow_r < (RowW+1)'(half_r)) ||
                (12'(rcol_r) + 12'(half_r) >= 12'(width_r)) ||
                (12'(rrow_r) + 12'(half_r) >= 12'(height_r));
  // pixel in window
  wire [RowW:0] prow = rrow_r + (RowW+1)'(wr_r) - (RowW+1)'(half_r);
  wire [11:0]   pcol = 12'(rcol_r) + 12'(wc_r) - 12'(half_r);
  wire [11:0]   lcol = pcol + 12'(d_r);
  wire [SlotW-1:0] slot = SlotW'(prow % LineRows);
  wire [SlotW-1:0] wslot = SlotW'(wrow_r % LineRows);
  wire [7:0] diff = (rq_r > lq_r) ? rq_r - lq_r : lq_r - rq_r;
  wire [SumW-1:0] sum_add = sum_r + (far_r ? FarCost : SumW'(diff));

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_SEND);
  assign out_ch.payload = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = !due ? ST_IDLE : (border ? ST_SEND : ST_READ);
      ST_READ:   state_nxt = ST_ACC;
      ST_ACC:    state_nxt = (wr_r == span && wc_r == span) ? ST_NEXT : ST_READ;
      ST_NEXT:   state_nxt = (d_r + 7'd1 >= levels_r) ? ST_SEND : ST_READ;
      ST_SEND:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid && !in_ch.payload.is_flush &&
        taken_r < total) begin
      lmem[{wslot, wcol_r}] <= in_ch.payload.left_pixel;
      rmem[{wslot, wcol_r}] <= in_ch.payload.right_pixel;
    end
    lq_r <= lmem[{slot, lcol[ColW-1:0]}];
    rq_r <= rmem[{slot, pcol[ColW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      width_r <= 11'd640; height_r <= 11'd480; levels_r <= 7'd16; half_r <= 3'd2;
      taken_r <= '0; given_r <= '0;
      wcol_r <= '0; wrow_r <= '0; rcol_r <= '0; rrow_r <= '0;
    end else if (cfg_we) begin
      state_r <= ST_IDLE;
      case (cfg_index)
        REG_WIDTH:  width_r <= (cfg_data == 11'd0) ? 11'd1 :
                               (cfg_data > 11'd1024 ? 11'd1024 : cfg_data);
        REG_HEIGHT: height_r <= (cfg_data == 11'd0) ? 11'd1 :
                                (cfg_data > 11'd1024 ? 11'd1024 : cfg_data);
        REG_DISP:   levels_r <= (cfg_data[6:0] == 7'd0) ? 7'd1 :
                                (cfg_data[6:0] > 7'd64 ? 7'd64 : cfg_data[6:0]);
        REG_HALF:   half_r <= cfg_data[2:0];
        default:    ;
      endcase
      taken_r <= '0; given_r <= '0;
      wcol_r <= '0; wrow_r <= '0; rcol_r <= '0; rrow_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: if (in_ch.valid) begin
          if (!in_ch.payload.is_flush && taken_r < total) begin
            taken_r <= taken_r + 21'd1;
            if (11'(wcol_r) + 11'd1 >= width_r) begin
              wcol_r <= '0; wrow_r <= wrow_r + 1'b1;
            end else wcol_r <= wcol_r + 1'b1;
          end
        end
        ST_DECIDE: begin
          res_r.out_row <= RowW'(rrow_r);
          res_r.out_col <= rcol_r;
          res_r.frame_end <= (given_r + 21'd1 >= total);
          res_r.disparity <= '0;
          d_r <= '0; wr_r <= '0; wc_r <= '0; sum_r <= '0;
          best_r <= '0;
        end
        ST_READ: far_r <= (lcol >= 12'(width_r));
        ST_ACC: begin
          sum_r <= sum_add;
          if (wc_r == span) begin
            wc_r <= '0; wr_r <= wr_r + 5'd1;
          end else wc_r <= wc_r + 5'd1;
        end
        ST_NEXT: begin
          if (d_r == 7'd0 || sum_r < best_r) begin
            best_r <= sum_r;
            res_r.disparity <= DispW'(d_r);
          end
          d_r <= d_r + 7'd1; wr_r <= '0; wc_r <= '0; sum_r <= '0;
        end
        ST_SEND: if (out_ch.ready) begin
          if (res_r.frame_end) begin
            taken_r <= '0; given_r <= '0;
            wcol_r <= '0; wrow_r <= '0; rcol_r <= '0; rrow_r <= '0;
          end else begin
            given_r <= given_r + 21'd1;
            if (11'(rcol_r) + 11'd1 >= width_r) begin
              rcol_r <= '0; rrow_r <= rrow_r + 1'b1;
            end else rcol_r <= rcol_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_res_order: assert property (@(posedge clk) disable iff (!rst_n)
    given_r <= taken_r) else $error("result ahead of pixels");
  a_best_disp: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> 7'(out_ch.payload.disparity) < levels_r)
    else $error("disparity out of range");
  a_send_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready && !cfg_we |=> out_ch.valid)
    else $error("result dropped");
`endif
endmodule
`default_nettype wire
